>>> hdl/mck_pkg.sv
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, codes and the Morse symbol table for the character keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int unsigned PatW   = 6;
  localparam int unsigned LenW   = 3;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CfgW   = 15;
  localparam int unsigned ToneW  = 15;
  localparam int unsigned DotW   = 10;
  localparam int unsigned GapW   = 13;
  localparam int unsigned ElemW  = 3;
  localparam int unsigned TxtW   = 7;

  localparam logic [IdxW-1:0] CFG_TEXT_MODE = 3'd0;
  localparam logic [IdxW-1:0] CFG_TONE_HZ   = 3'd1;
  localparam logic [IdxW-1:0] CFG_DOT_MS    = 3'd2;
  localparam logic [IdxW-1:0] CFG_INTRA_GAP = 3'd3;
  localparam logic [IdxW-1:0] CFG_CHAR_GAP  = 3'd4;
  localparam logic [IdxW-1:0] CFG_WORD_GAP  = 3'd5;

  localparam logic [ElemW-1:0] EL_DOT       = 3'd0;
  localparam logic [ElemW-1:0] EL_DASH      = 3'd1;
  localparam logic [ElemW-1:0] EL_INTRA_GAP = 3'd2;
  localparam logic [ElemW-1:0] EL_CHAR_GAP  = 3'd3;
  localparam logic [ElemW-1:0] EL_WORD_GAP  = 3'd4;

  localparam logic [TxtW-1:0] TXT_DOT   = 7'h2E;
  localparam logic [TxtW-1:0] TXT_DASH  = 7'h2D;
  localparam logic [TxtW-1:0] TXT_SPACE = 7'h20;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic             text_mode;
    logic [ToneW-1:0] tone_hz;
    logic [DotW-1:0]  dot_ms;
    logic [GapW-1:0]  intra_gap_ms;
    logic [GapW-1:0]  char_gap_ms;
    logic [GapW-1:0]  word_gap_ms;
  } mck_cfg_t;

  typedef struct packed {
    logic            hit;
    logic [LenW-1:0] len;
    logic [PatW-1:0] pattern;
  } mck_sym_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELEM,
    ST_GAP,
    ST_CHAR,
    ST_WORD
  } mck_state_t;

  // Look up a character; the pattern comes back with its first element at the MSB.
  function automatic mck_sym_t mck_lookup(input logic [7:0] code);
    logic [7:0]      c;
    logic [LenW-1:0] len;
    logic [PatW-1:0] bits;
    logic            hit;
    mck_sym_t        sym;
    c    = code;
    len  = '0;
    bits = '0;
    hit  = 1'b1;
    if (code >= 8'h61 && code <= 8'h7A) begin
      c = code - 8'd32;
    end
    case (c)
      8'h41: begin len = 3'd2; bits = 6'd1;  end
      8'h42: begin len = 3'd4; bits = 6'd8;  end
      8'h43: begin len = 3'd4; bits = 6'd10; end
      8'h44: begin len = 3'd3; bits = 6'd4;  end
      8'h45: begin len = 3'd1; bits = 6'd0;  end
      8'h46: begin len = 3'd4; bits = 6'd2;  end
      8'h47: begin len = 3'd3; bits = 6'd6;  end
      8'h48: begin len = 3'd4; bits = 6'd0;  end
      8'h49: begin len = 3'd2; bits = 6'd0;  end
      8'h4A: begin len = 3'd4; bits = 6'd7;  end
      8'h4B: begin len = 3'd3; bits = 6'd5;  end
      8'h4C: begin len = 3'd4; bits = 6'd4;  end
      8'h4D: begin len = 3'd2; bits = 6'd3;  end
      8'h4E: begin len = 3'd2; bits = 6'd2;  end
      8'h4F: begin len = 3'd3; bits = 6'd7;  end
      8'h50: begin len = 3'd4; bits = 6'd6;  end
      8'h51: begin len = 3'd4; bits = 6'd13; end
      8'h52: begin len = 3'd3; bits = 6'd2;  end
      8'h53: begin len = 3'd3; bits = 6'd0;  end
      8'h54: begin len = 3'd1; bits = 6'd1;  end
      8'h55: begin len = 3'd3; bits = 6'd1;  end
      8'h56: begin len = 3'd4; bits = 6'd1;  end
      8'h57: begin len = 3'd3; bits = 6'd3;  end
      8'h58: begin len = 3'd4; bits = 6'd9;  end
      8'h59: begin len = 3'd4; bits = 6'd11; end
      8'h5A: begin len = 3'd4; bits = 6'd12; end
      8'h30: begin len = 3'd5; bits = 6'd31; end
      8'h31: begin len = 3'd5; bits = 6'd15; end
      8'h32: begin len = 3'd5; bits = 6'd7;  end
      8'h33: begin len = 3'd5; bits = 6'd3;  end
      8'h34: begin len = 3'd5; bits = 6'd1;  end
      8'h35: begin len = 3'd5; bits = 6'd0;  end
      8'h36: begin len = 3'd5; bits = 6'd16; end
      8'h37: begin len = 3'd5; bits = 6'd24; end
      8'h38: begin len = 3'd5; bits = 6'd28; end
      8'h39: begin len = 3'd5; bits = 6'd30; end
      8'h26: begin len = 3'd5; bits = 6'd8;  end
      8'h27: begin len = 3'd6; bits = 6'd30; end
      8'h40: begin len = 3'd6; bits = 6'd26; end
      8'h29: begin len = 3'd6; bits = 6'd45; end
      8'h28: begin len = 3'd5; bits = 6'd22; end
      8'h3A: begin len = 3'd6; bits = 6'd56; end
      8'h2C: begin len = 3'd6; bits = 6'd51; end
      8'h3D: begin len = 3'd5; bits = 6'd17; end
      8'h21: begin len = 3'd6; bits = 6'd43; end
      8'h2E: begin len = 3'd6; bits = 6'd21; end
      8'h2D: begin len = 3'd6; bits = 6'd33; end
      8'h3F: begin len = 3'd6; bits = 6'd12; end
      default: hit = 1'b0;
    endcase
    sym.hit     = hit;
    sym.len     = len;
    sym.pattern = bits << (3'd6 - len);
    return sym;
  endfunction

endpackage

>>> hdl/mck_cfg.sv
// ----------------------------------------------------------------------------
// mck_cfg
// Configuration register file with reset defaults, written by index.
// ----------------------------------------------------------------------------
module mck_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [mck_pkg::IdxW-1:0] cfg_index,
  input  logic [mck_pkg::CfgW-1:0] cfg_data,
  output mck_pkg::mck_cfg_t     cfg
);
  import mck_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_mode    <= 1'b0;
      cfg.tone_hz      <= 15'd800;
      cfg.dot_ms       <= 10'd70;
      cfg.intra_gap_ms <= 13'd70;
      cfg.char_gap_ms  <= 13'd140;
      cfg.word_gap_ms  <= 13'd350;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_MODE: cfg.text_mode    <= cfg_data[0];
        CFG_TONE_HZ:   cfg.tone_hz      <= cfg_data[ToneW-1:0];
        CFG_DOT_MS:    cfg.dot_ms       <= cfg_data[DotW-1:0];
        CFG_INTRA_GAP: cfg.intra_gap_ms <= cfg_data[GapW-1:0];
        CFG_CHAR_GAP:  cfg.char_gap_ms  <= cfg_data[GapW-1:0];
        CFG_WORD_GAP:  cfg.word_gap_ms  <= cfg_data[GapW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/mck_keyer.sv
// ----------------------------------------------------------------------------
// mck_keyer
// Element sequencer: shifts the Morse pattern out one element at a time into
// a registered result stage; a stall on the output holds it.
// ----------------------------------------------------------------------------
module mck_keyer (
  input  logic                      clk,
  input  logic                      rst,
  input  mck_pkg::mck_cfg_t         cfg,
  input  logic                      char_valid,
  output logic                      char_stall,
  input  logic [7:0]                char_code,
  output logic                      elem_valid,
  input  logic                      elem_stall,
  output logic [mck_pkg::ElemW-1:0] element,
  output logic                      tone_on,
  output logic [mck_pkg::ToneW-1:0] frequency_hz,
  output logic [mck_pkg::GapW-1:0]  duration_ms,
  output logic [mck_pkg::TxtW-1:0]  text_char,
  output logic                      last
);
  import mck_pkg::*;

  mck_state_t      state, state_next;
  logic [PatW-1:0] pattern, pattern_next;
  logic [LenW-1:0] count, count_next;
  logic [1:0]      word_cnt, word_cnt_next;
  logic            elem_valid_next;

  logic             emit;
  logic             accept;
  logic             dash;
  mck_sym_t         sym;
  logic [GapW-1:0]  dash_ms;
  logic [ElemW-1:0] r_element;
  logic             r_tone_on;
  logic [ToneW-1:0] r_frequency_hz;
  logic [GapW-1:0]  r_duration_ms;
  logic [TxtW-1:0]  r_text_char;
  logic             r_last;

  assign sym     = mck_lookup(char_code);
  assign dash    = pattern[PatW-1];
  assign dash_ms = GapW'({cfg.dot_ms, 1'b0}) + GapW'(cfg.dot_ms);
  assign char_stall = (state != ST_IDLE);
  assign accept  = char_valid && !char_stall;
  assign emit    = (state != ST_IDLE) && (!elem_valid || !elem_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_valid <= 1'b0;
    end else begin
      elem_valid <= elem_valid_next;
    end
    pattern  <= pattern_next;
    count    <= count_next;
    word_cnt <= word_cnt_next;
    if (emit) begin
      element      <= r_element;
      tone_on      <= r_tone_on;
      frequency_hz <= r_frequency_hz;
      duration_ms  <= r_duration_ms;
      text_char    <= r_text_char;
      last         <= r_last;
    end
  end

  always_comb begin
    state_next      = state;
    pattern_next    = pattern;
    count_next      = count;
    word_cnt_next   = word_cnt;
    r_element       = EL_CHAR_GAP;
    r_tone_on       = 1'b0;
    r_frequency_hz  = '0;
    r_duration_ms   = '0;
    r_text_char     = '0;
    r_last          = 1'b0;
    elem_valid_next = emit ? 1'b1 : (elem_valid && elem_stall);

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (char_code == CHAR_SPACE) begin
            state_next    = ST_WORD;
            word_cnt_next = cfg.text_mode ? 2'd2 : 2'd0;
          end else if (sym.hit) begin
            state_next   = ST_ELEM;
            pattern_next = sym.pattern;
            count_next   = sym.len;
          end
        end
      end
      ST_ELEM: begin
        r_element = dash ? EL_DASH : EL_DOT;
        if (cfg.text_mode) begin
          r_text_char = dash ? TXT_DASH : TXT_DOT;
        end else begin
          r_tone_on      = 1'b1;
          r_frequency_hz = cfg.tone_hz;
          r_duration_ms  = dash ? dash_ms : GapW'(cfg.dot_ms);
        end
        if (emit) begin
          pattern_next = {pattern[PatW-2:0], 1'b0};
          count_next   = count - 3'd1;
          if (!cfg.text_mode) begin
            state_next = ST_GAP;
          end else if (count == 3'd1) begin
            state_next = ST_CHAR;
          end
        end
      end
      ST_GAP: begin
        r_element     = EL_INTRA_GAP;
        r_duration_ms = cfg.intra_gap_ms;
        if (emit) begin
          state_next = (count == 3'd0) ? ST_CHAR : ST_ELEM;
        end
      end
      ST_CHAR: begin
        r_element = EL_CHAR_GAP;
        r_last    = 1'b1;
        if (cfg.text_mode) begin
          r_text_char = TXT_SPACE;
        end else begin
          r_duration_ms = cfg.char_gap_ms;
        end
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      ST_WORD: begin
        r_element = EL_WORD_GAP;
        r_last    = (word_cnt == 2'd0);
        if (cfg.text_mode) begin
          r_text_char = TXT_SPACE;
        end else begin
          r_duration_ms = cfg.word_gap_ms;
        end
        if (emit) begin
          if (word_cnt == 2'd0) begin
            state_next = ST_IDLE;
          end else begin
            word_cnt_next = word_cnt - 2'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/morse_character_keyer_unit.sv
// ----------------------------------------------------------------------------
// morse_character_keyer_unit
// Morse encoder: one ASCII character in, its Morse elements out in order.
//
// Input channel char_valid/char_stall carries char_code. Output channel
// elem_valid/elem_stall carries one element per item: element code, tone_on,
// frequency_hz, duration_ms, text_char and last (set on a character's final
// element). Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce; indexes beyond the register list are ignored.
// A character is taken when the sequencer is idle. Once the state register
// has left idle its first element enters the output register, and the rest
// follow one per cycle while the receiver does not stall.
// Unknown characters are consumed and give no output.
// A stall on the output holds the result register and the sequencer; the
// next character is taken once the final element has entered the result
// register, even while it still waits to be taken.
// Reset restores the register defaults and empties the output register.
// ----------------------------------------------------------------------------
module morse_character_keyer_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mck_pkg::IdxW-1:0]  cfg_index,
  input  logic [mck_pkg::CfgW-1:0]  cfg_data,
  input  logic                      char_valid,
  output logic                      char_stall,
  input  logic [7:0]                char_code,
  output logic                      elem_valid,
  input  logic                      elem_stall,
  output logic [mck_pkg::ElemW-1:0] element,
  output logic                      tone_on,
  output logic [mck_pkg::ToneW-1:0] frequency_hz,
  output logic [mck_pkg::GapW-1:0]  duration_ms,
  output logic [mck_pkg::TxtW-1:0]  text_char,
  output logic                      last
);
  import mck_pkg::*;

  mck_cfg_t cfg;

  mck_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mck_keyer u_keyer (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .elem_valid   (elem_valid),
    .elem_stall   (elem_stall),
    .element      (element),
    .tone_on      (tone_on),
    .frequency_hz (frequency_hz),
    .duration_ms  (duration_ms),
    .text_char    (text_char),
    .last         (last)
  );

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for morse_character_keyer_unit. Characters go in on the
// char_valid/char_stall channel. A predictor in this file models the Morse
// table, both output modes and the register file. It queues the element items
// that each accepted character should produce. A checker compares every
// accepted element item, field by field, against the oldest queued item.
// The input idles and the output stalls at random. Registers change only
// while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import mck_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam logic [IdxW-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [IdxW-1:0] CFG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [ElemW-1:0] element;
    logic             tone_on;
    logic [ToneW-1:0] freq;
    logic [GapW-1:0]  dur;
    logic [TxtW-1:0]  txt;
    logic             last;
  } keyed_elem_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [IdxW-1:0]   cfg_index = '0;
  logic [CfgW-1:0]   cfg_data = '0;
  logic              char_valid = 1'b0;
  logic              char_stall;
  logic [7:0]        char_code = 8'h00;
  logic              elem_valid;
  logic              elem_stall = 1'b0;
  logic [ElemW-1:0]  element;
  logic              tone_on;
  logic [ToneW-1:0]  frequency_hz;
  logic [GapW-1:0]   duration_ms;
  logic [TxtW-1:0]   text_char;
  logic              last;

  mck_cfg_t    key_cfg;
  keyed_elem_t pending_elems[$];
  int          gap_pct = 30;
  int          stall_pct = 30;
  int          stall_left = 0;
  int          errors = 0;
  int          chars_sent = 0;
  int          elems_checked = 0;
  int          reg_writes = 0;
  int          cycles = 0;

  string       sym_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789&'@)(:,=!.-?";
  byte unsigned sym_len [48] = '{2, 4, 4, 3, 1, 4, 3, 4, 2, 4, 3, 4, 2, 2, 3, 4, 4, 3, 3,
                                 1, 3, 4, 3, 4, 4, 4, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5,
                                 5, 6, 6, 6, 5, 6, 6, 5, 6, 6, 6, 6};
  byte unsigned sym_bits [48] = '{1, 8, 10, 4, 0, 2, 6, 0, 0, 7, 5, 4, 3, 2, 7, 6, 13, 2,
                                  0, 1, 1, 1, 3, 9, 11, 12, 31, 15, 7, 3, 1, 0, 16, 24,
                                  28, 30, 8, 30, 26, 45, 22, 56, 51, 17, 43, 21, 33, 12};

  morse_character_keyer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .elem_valid   (elem_valid),
    .elem_stall   (elem_stall),
    .element      (element),
    .tone_on      (tone_on),
    .frequency_hz (frequency_hz),
    .duration_ms  (duration_ms),
    .text_char    (text_char),
    .last         (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic logic [CfgW-1:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return CfgW'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 10) return CHAR_SPACE;
    if (r < 20) return 8'($urandom);
    c = sym_chars[$urandom_range(0, 47)];
    if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + 8'd32;
    return c;
  endfunction

  function automatic void queue_elem(input logic [ElemW-1:0] el, input logic tone,
                                     input logic [ToneW-1:0] freq,
                                     input logic [GapW-1:0] dur,
                                     input logic [TxtW-1:0] txt);
    keyed_elem_t e;
    e.element = el;
    e.tone_on = tone;
    e.freq    = freq;
    e.dur     = dur;
    e.txt     = txt;
    e.last    = 1'b0;
    pending_elems.push_back(e);
  endfunction

  function automatic void predict_keying(input logic [7:0] ch);
    int          first;
    int          idx;
    int          n;
    logic [7:0]  up;
    logic [5:0]  pat;
    logic        dash;
    keyed_elem_t e;
    first = pending_elems.size();
    idx   = -1;
    if (ch == CHAR_SPACE) begin
      if (key_cfg.text_mode) begin
        repeat (3) queue_elem(EL_WORD_GAP, 1'b0, '0, '0, TXT_SPACE);
      end else begin
        queue_elem(EL_WORD_GAP, 1'b0, '0, key_cfg.word_gap_ms, '0);
      end
    end else begin
      up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
      for (int i = 0; i < 48; i++) begin
        if (idx < 0 && sym_chars[i] == up) idx = i;
      end
      if (idx >= 0) begin
        n   = sym_len[idx];
        pat = 6'(sym_bits[idx]);
        for (int k = n - 1; k >= 0; k--) begin
          dash = pat[k];
          if (key_cfg.text_mode) begin
            queue_elem(dash ? EL_DASH : EL_DOT, 1'b0, '0, '0, dash ? TXT_DASH : TXT_DOT);
          end else begin
            queue_elem(dash ? EL_DASH : EL_DOT, 1'b1, key_cfg.tone_hz,
                       dash ? GapW'(key_cfg.dot_ms) * 13'd3 : GapW'(key_cfg.dot_ms), '0);
            queue_elem(EL_INTRA_GAP, 1'b0, '0, key_cfg.intra_gap_ms, '0);
          end
        end
        if (key_cfg.text_mode) begin
          queue_elem(EL_CHAR_GAP, 1'b0, '0, '0, TXT_SPACE);
        end else begin
          queue_elem(EL_CHAR_GAP, 1'b0, '0, key_cfg.char_gap_ms, '0);
        end
      end
    end
    if (pending_elems.size() > first) begin
      e = pending_elems.pop_back();
      e.last = 1'b1;
      pending_elems.push_back(e);
    end
  endfunction

  task automatic send_char(input logic [7:0] ch);
    int idle;
    idle = pick_gap(gap_pct);
    if (idle > 0) begin
      char_valid <= 1'b0;
      char_code  <= 8'($urandom);
      repeat (idle) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= ch;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    predict_keying(ch);
    chars_sent++;
  endtask

  // drop valid, drain expected items, then let an unknown character finish
  task automatic settle();
    char_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TEXT_MODE: key_cfg.text_mode    = val[0];
      CFG_TONE_HZ:   key_cfg.tone_hz      = val[ToneW-1:0];
      CFG_DOT_MS:    key_cfg.dot_ms       = val[DotW-1:0];
      CFG_INTRA_GAP: key_cfg.intra_gap_ms = val[GapW-1:0];
      CFG_CHAR_GAP:  key_cfg.char_gap_ms  = val[GapW-1:0];
      CFG_WORD_GAP:  key_cfg.word_gap_ms  = val[GapW-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic test_default_keying();
    send_char(8'h00);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(8'hFF);
    send_text("AzET09?' #");
    settle();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_DOT_MS, 15'h0000);
    write_reg(CFG_TONE_HZ, 15'h7FFF);
    write_reg(CFG_INTRA_GAP, 15'h7FFF);
    write_reg(CFG_CHAR_GAP, 15'h7FFF);
    write_reg(CFG_WORD_GAP, 15'h7FFF);
    send_text("Q 5");
    settle();
    write_reg(CFG_DOT_MS, 15'h7FFF);
    write_reg(CFG_TONE_HZ, 15'h0000);
    write_reg(CFG_INTRA_GAP, 15'h0000);
    write_reg(CFG_CHAR_GAP, 15'h0000);
    write_reg(CFG_WORD_GAP, 15'h0000);
    send_text("0 ");
    settle();
  endtask

  task automatic test_text_mode();
    write_reg(CFG_TEXT_MODE, 15'h0001);
    send_text(" .-x");
    settle();
    write_reg(CFG_TEXT_MODE, 15'h7FFE);
  endtask

  task automatic test_unused_index();
    write_reg(CFG_UNUSED_LO, 15'h7FFF);
    write_reg(CFG_UNUSED_HI, 15'h0001);
    send_char("K");
    settle();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = CFG_TEXT_MODE; r <= CFG_WORD_GAP; r++) write_reg(IdxW'(r), pick_reg_value());
      write_reg(CFG_TEXT_MODE, {14'($urandom), ph[0]});
      gap_pct   = (ph < 2) ? 0 : (ph == 3) ? 70 : 25;
      stall_pct = (ph < 2) ? 0 : (ph == 4) ? 70 : 25;
      repeat (48) send_char(pick_char());
      settle();
    end
  endtask

  always @(posedge clk) begin
    keyed_elem_t got;
    keyed_elem_t want;
    if (!rst && elem_valid && !elem_stall) begin
      got = '{element, tone_on, frequency_hz, duration_ms, text_char, last};
      if (pending_elems.size() == 0) begin
        errors++;
        $display("%0t: unexpected item el=%0d tone=%0b f=%0d d=%0d t=%02h last=%0b",
                 $time, got.element, got.tone_on, got.freq, got.dur, got.txt, got.last);
      end else begin
        want = pending_elems.pop_front();
        elems_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected el=%0d tone=%0b f=%0d d=%0d t=%02h last=%0b",
                   $time, want.element, want.tone_on, want.freq, want.dur, want.txt,
                   want.last);
          $display("%0t: mismatch actual   el=%0d tone=%0b f=%0d d=%0d t=%02h last=%0b",
                   $time, got.element, got.tone_on, got.freq, got.dur, got.txt,
                   got.last);
        end
      end
    end
    if (stall_left > 0) begin
      elem_stall <= 1'b1;
      stall_left--;
    end else if (pick_gap(stall_pct) > 0) begin
      elem_stall <= 1'b1;
      stall_left = pick_gap(100) - 1;
    end else begin
      elem_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout, %0d items outstanding", $time, pending_elems.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    key_cfg = '{text_mode: 1'b0, tone_hz: 15'd800, dot_ms: 10'd70, intra_gap_ms: 13'd70,
                char_gap_ms: 13'd140, word_gap_ms: 13'd350};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_default_keying();
    test_register_extremes();
    test_text_mode();
    test_unused_index();
    test_random_traffic();
    repeat (20) @(posedge clk);
    $display("tb summary: %0d characters sent, %0d items checked, %0d register writes",
             chars_sent, elems_checked, reg_writes);
    $display("tb summary: tone and text modes, register extremes, unknown codes, stalls");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
